[src/tds_pkg.sv]
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants of the tridiagonal solver
// Field widths and the word type.
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 6;

    typedef logic signed [WORD_W-1:0] word_t;

endpackage

[src/tds_if.sv]
// ----------------------------------------------------------------------------
// tds_row_if / tds_sol_if: row input and solution output channels
// Valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface tds_row_if;
    logic valid;
    logic ready;
    tds_pkg::word_t sub_diag;
    tds_pkg::word_t main_diag;
    tds_pkg::word_t super_diag;
    tds_pkg::word_t rhs_value;
    logic last_row;
    modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                    input ready);
    modport sink (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                  output ready);
endinterface

interface tds_sol_if;
    logic valid;
    logic ready;
    tds_pkg::word_t solution_value;
    logic [tds_pkg::IDX_W-1:0] row_index;
    logic last_result;
    logic div_error;
    modport source (output valid, solution_value, row_index, last_result, div_error,
                    input ready);
    modport sink (input valid, solution_value, row_index, last_result, div_error,
                  output ready);
endinterface

[src/tridiagonal_system_solver_core.sv]
// A row passes read, multiply, sum, check, two serial divisions (one quotient
// bit a cycle) and write before the next row can be taken; a zero-pivot row
// skips the divisions. Back substitution: stored rows in turn, last row first,
// each word held until taken. Asynchronous active-low reset clears row count,
// error flag and control; the factor memories are left unset.
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_core: Thomas algorithm tridiagonal solver
// Forward sweep per row into p/q memories, then back substitution.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_core #(
    parameter int MAX_ROWS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tds_row_if.sink   row_in,
    tds_sol_if.source sol_out
);
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_MUL   = 11'b00000000100,
        S_SUM   = 11'b00000001000,
        S_CHK   = 11'b00000010000,
        S_DIVP  = 11'b00000100000,
        S_DIVQ  = 11'b00001000000,
        S_WR    = 11'b00010000000,
        S_BRD   = 11'b00100000000,
        S_BMUL  = 11'b01000000000,
        S_BOUT  = 11'b10000000000
    } state_t;

    state_t state_reg;

    tds_pkg::word_t p_mem [MAX_ROWS];
    tds_pkg::word_t q_mem [MAX_ROWS];
    tds_pkg::word_t p_rd_reg, q_rd_reg;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;

    logic [CW-1:0]  row_count_reg;
    logic           error_reg;
    logic [AW-1:0]  bidx_reg;
    logic           first_reg;

    tds_pkg::word_t a_reg, b_reg, c_reg, d_reg;
    logic           last_reg;
    logic signed [63:0] prod1_reg, prod2_reg;
    tds_pkg::word_t den_reg, numq_reg, p_reg, q_reg, x_reg;

    logic           div_start;
    logic           div_done;
    logic [32:0]    div_num;
    tds_pkg::word_t div_quo;

    tds_pkg::word_t sol_reg;
    logic           sol_valid_reg;
    logic [AW-1:0]  sol_idx_reg;
    logic           sol_err_reg;

    function automatic tds_pkg::word_t sat33(input logic signed [32:0] v);
        if (v > 33'sh07FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (v < -33'sh080000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic tds_pkg::word_t qround(input logic signed [63:0] pr);
        logic signed [64:0] s;
        logic signed [64:0] r;
        s = 65'(pr) + (65'sd1 <<< (FRAC_BITS - 1));
        r = s >>> FRAC_BITS;
        if (r > 65'sh07FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (r < -65'sh080000000)
            return 32'sh80000000;
        return r[31:0];
    endfunction

    assign row_in.ready = (state_reg == S_IDLE) && !sol_valid_reg;

    // previous row's factors stay addressed until the multiply stage
    always_comb
    begin
        if (state_reg == S_IDLE || state_reg == S_RD)
            rd_addr = AW'(row_count_reg - CW'(1));
        else
            rd_addr = bidx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            p_mem[row_count_reg[AW-1:0]] <= p_reg;
            q_mem[row_count_reg[AW-1:0]] <= q_reg;
        end
        p_rd_reg <= p_mem[rd_addr];
        q_rd_reg <= q_mem[rd_addr];
    end

    assign wr_en = (state_reg == S_WR);
    assign div_start = ((state_reg == S_CHK) && den_reg != 0)
                    || ((state_reg == S_DIVP) && div_done);
    assign div_num = (state_reg == S_CHK) ? -(33'(c_reg)) : 33'(numq_reg);

    tds_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            error_reg     <= 1'b0;
            sol_valid_reg <= 1'b0;
            bidx_reg      <= '0;
            first_reg     <= 1'b0;
        end
        else
        begin
            if (sol_valid_reg && sol_out.ready)
            begin
                sol_valid_reg <= 1'b0;
                if (sol_idx_reg == '0)
                begin
                    row_count_reg <= '0;
                    error_reg     <= 1'b0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                    if (row_in.valid && row_in.ready)
                        state_reg <= S_RD;
                S_RD:    state_reg <= S_MUL;
                S_MUL:   state_reg <= S_SUM;
                S_SUM:   state_reg <= S_CHK;
                S_CHK:
                    if (den_reg == 0)
                    begin
                        error_reg <= 1'b1;
                        state_reg <= S_WR;
                    end
                    else
                        state_reg <= S_DIVP;
                S_DIVP:
                    if (div_done)
                        state_reg <= S_DIVQ;
                S_DIVQ:
                    if (div_done)
                        state_reg <= S_WR;
                S_WR:
                begin
                    row_count_reg <= row_count_reg + CW'(1);
                    if (last_reg || row_count_reg == CW'(MAX_ROWS - 1))
                    begin
                        bidx_reg  <= row_count_reg[AW-1:0];
                        first_reg <= 1'b1;
                        state_reg <= S_BRD;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_BRD:
                    if (!sol_valid_reg)
                        state_reg <= S_BMUL;
                S_BMUL:  state_reg <= S_BOUT;
                S_BOUT:
                begin
                    sol_valid_reg <= 1'b1;
                    first_reg     <= 1'b0;
                    if (bidx_reg == '0)
                        state_reg <= S_IDLE;
                    else
                    begin
                        bidx_reg  <= bidx_reg - AW'(1);
                        state_reg <= S_BRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath: two multiplies in the multiply stage, one in the back multiply stage
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (row_in.valid && row_in.ready)
                begin
                    a_reg    <= row_in.sub_diag;
                    b_reg    <= row_in.main_diag;
                    c_reg    <= row_in.super_diag;
                    d_reg    <= row_in.rhs_value;
                    last_reg <= row_in.last_row;
                end
            S_RD:  ;
            S_MUL:
            begin
                prod1_reg <= a_reg * p_rd_reg;
                prod2_reg <= a_reg * q_rd_reg;
            end
            S_SUM:
            begin
                if (row_count_reg == '0)
                begin
                    den_reg  <= b_reg;
                    numq_reg <= d_reg;
                end
                else
                begin
                    den_reg  <= sat33(33'(b_reg) + 33'(qround(prod1_reg)));
                    numq_reg <= sat33(33'(d_reg) - 33'(qround(prod2_reg)));
                end
                // zero pivot leaves both factors at zero
                p_reg <= '0;
                q_reg <= '0;
            end
            S_CHK: ;
            S_DIVP:
                if (div_done)
                    p_reg <= div_quo;
            S_DIVQ:
                if (div_done)
                    q_reg <= div_quo;
            S_WR:  ;
            S_BRD: ;
            S_BMUL:
                prod1_reg <= p_rd_reg * x_reg;
            S_BOUT:
            begin
                if (first_reg)
                    x_reg <= q_rd_reg;
                else
                    x_reg <= sat33(33'(qround(prod1_reg)) + 33'(q_rd_reg));
                sol_idx_reg <= bidx_reg;
                sol_err_reg <= error_reg;
            end
            default: ;
        endcase
    end

    assign sol_reg = x_reg;

    assign sol_out.valid          = sol_valid_reg;
    assign sol_out.solution_value = sol_reg;
    assign sol_out.row_index      = tds_pkg::IDX_W'(sol_idx_reg);
    assign sol_out.last_result    = (sol_idx_reg == '0);
    assign sol_out.div_error      = sol_err_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !row_in.ready)
        else $error("row accepted while busy");
    a_wr_only_wr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_WR))
        else $error("factor write outside write stage");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= CW'(MAX_ROWS))
        else $error("row count overflow");
endmodule

[src/tds_divider.sv]
// ----------------------------------------------------------------------------
// tds_divider: restoring fixed-point divider
// (num << FRAC_BITS) / den, truncated toward zero, saturated, one bit a cycle.
// ----------------------------------------------------------------------------
module tds_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [32:0]    num,      // signed, one bit wider to hold -c
    input  tds_pkg::word_t den,
    output logic           done,
    output tds_pkg::word_t quo
);
    localparam int NW = 33 + FRAC_BITS;   // dividend magnitude width
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   dmag_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg;

    logic [33:0]   trial;
    logic [32:0]   nmag;
    logic [NW-1:0] qmax;

    always_comb
    begin
        nmag = num[32] ? (~num + 33'd1) : num;
        trial = {rem_reg, dvd_reg[NW-1]} - {2'b00, dmag_reg};
        dvd_next = dvd_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next = {nmag, {FRAC_BITS{1'b0}}};
            q_next = '0;
            rem_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[NW-2:0], 1'b0};
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], dvd_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dmag_reg <= den[31] ? (~den + 32'd1) : den;
            neg_reg  <= num[32] ^ den[31];
        end
    end

    always_comb
    begin
        qmax = NW'(32'h7FFFFFFF);
        if (neg_reg)
            quo = (q_reg > qmax + NW'(1)) ? 32'sh80000000 : 32'(~q_reg + NW'(1));
        else
            quo = (q_reg > qmax) ? 32'sh7FFFFFFF : 32'(q_reg);
    end

    assign done = done_reg;
endmodule
